// ===== sv/cpp_source_token_classifier_macros.svh =====
// assertion macros for the token classifier checker
// no dependencies
`ifndef CPP_SOURCE_TOKEN_CLASSIFIER_MACROS_SVH
`define CPP_SOURCE_TOKEN_CLASSIFIER_MACROS_SVH
`define CTC_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define CTC_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// ===== sv/ctc_pkg.sv =====
// shared types, constants and byte classes for the token classifier
// no dependencies
package ctc_pkg;
    localparam int MAX_DELIM_DEF  = 16;
    localparam int COUNT_BITS_DEF = 24;
    localparam int FIELD_W        = 24;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [2:0] KIND_SPACE   = 3'd0;
    localparam logic [2:0] KIND_COMMENT = 3'd1;
    localparam logic [2:0] KIND_STRING  = 3'd2;
    localparam logic [2:0] KIND_CHAR    = 3'd3;
    localparam logic [2:0] KIND_IDENT   = 3'd4;
    localparam logic [2:0] KIND_NUMBER  = 3'd5;
    localparam logic [2:0] KIND_SYMBOL  = 3'd6;
    localparam logic [2:0] KIND_END     = 3'd7;

    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_UNDER  = 8'h5f;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         token_kind;
        logic [FIELD_W-1:0] start_offset;
        logic [FIELD_W-1:0] token_length;
        logic [FIELD_W-1:0] first_line;
        logic [FIELD_W-1:0] first_column;
        logic               delim_overflow;
        logic               last_token;
    } out_item_t;

    // up to three tokens per byte: the one closed, a symbol or the flushed open token, and the end token
    typedef struct packed {
        logic       v0;
        out_item_t  t0;
        logic       v1;
        out_item_t  t1;
        logic       v2;
        out_item_t  t2;
    } token_group_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_word(input logic [7:0] b);
        return is_alpha(b) || is_digit(b) || (b == CH_UNDER);
    endfunction
endpackage

// ===== sv/ctc_front.sv =====
// front end: lexer state machine, takes one byte per transfer, emits a token group
// depends on ctc_pkg
module ctc_front #(
    parameter int MAX_DELIM  = ctc_pkg::MAX_DELIM_DEF,
    parameter int COUNT_BITS = ctc_pkg::COUNT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  ctc_pkg::in_item_t     in_item,
    output logic                  in_ready,
    output logic                  grp_valid,
    output ctc_pkg::token_group_t grp,
    input  logic                  grp_ready
);
    localparam int HIST_LEN = MAX_DELIM + 2;
    localparam int DL_W     = $clog2(MAX_DELIM + 1);
    localparam int BC_W     = $clog2(HIST_LEN + 1);
    localparam int FW       = ctc_pkg::FIELD_W;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;
    localparam logic [COUNT_BITS-1:0] ONE  = COUNT_BITS'(1);

    localparam logic [3:0] M_IDLE = 4'd0, M_WS = 4'd1, M_LINE = 4'd2, M_BLOCK = 4'd3,
        M_SLASH = 4'd4, M_RPEND = 4'd5, M_IDENT = 4'd6, M_NUMBER = 4'd7, M_STRING = 4'd8,
        M_CHAR = 4'd9, M_RAWDELIM = 4'd10, M_RAWBODY = 4'd11, M_RAWOVF = 4'd12;

    logic [3:0]            mode_reg, mode_next;
    logic [COUNT_BITS-1:0] off_reg, off_next, line_reg, line_next, col_reg, col_next;
    logic [COUNT_BITS-1:0] tstart_reg, tstart_next, tline_reg, tline_next;
    logic [COUNT_BITS-1:0] tcol_reg, tcol_next;
    logic                  esc_reg, esc_next, star_reg, star_next;
    logic [DL_W-1:0]       dlen_reg, dlen_next;
    logic [BC_W-1:0]       bcnt_reg, bcnt_next;
    logic [7:0]            delim_reg [MAX_DELIM];
    logic [7:0]            hist_reg [HIST_LEN];
    logic                  grp_valid_reg;
    ctc_pkg::token_group_t grp_reg, grp_next;

    logic take;
    assign in_ready  = !grp_valid_reg || grp_ready;
    assign take      = in_valid && in_ready;
    assign grp_valid = grp_valid_reg;
    assign grp       = grp_reg;

    function automatic ctc_pkg::out_item_t mk(input logic [2:0] k,
        input logic [COUNT_BITS-1:0] so, input logic [COUNT_BITS-1:0] en,
        input logic [COUNT_BITS-1:0] ln, input logic [COUNT_BITS-1:0] cl,
        input logic ovf, input logic last);
        ctc_pkg::out_item_t t;
        logic [COUNT_BITS-1:0] len;
        len = (en >= so) ? en - so : '0;
        t.token_kind     = k;
        t.start_offset   = FW'(so);
        t.token_length   = FW'(len);
        t.first_line     = FW'(ln);
        t.first_column   = FW'(cl);
        t.delim_overflow = ovf;
        t.last_token     = last;
        return t;
    endfunction

    // close match against the shifted history, compares in parallel
    logic       closed;
    logic [7:0] b;
    logic [7:0] nh [HIST_LEN];
    always_comb
    begin
        logic ok;
        nh[0] = b;
        for (int i = 1; i < HIST_LEN; i++)
            nh[i] = hist_reg[i-1];
        closed = 1'b0;
        ok = 1'b0;
        for (int L = 0; L <= MAX_DELIM; L++)
        begin
            if (DL_W'(L) == dlen_reg)
            begin
                ok = (nh[0] == ctc_pkg::CH_DQUOTE) && (nh[L+1] == ctc_pkg::CH_RPAREN);
                for (int k = 1; k <= L; k++)
                    if (nh[k] != delim_reg[L-k])
                        ok = 1'b0;
                closed = ok && (32'(bcnt_reg) + 1 >= L + 2);
            end
        end
    end

    always_comb
    begin
        logic [COUNT_BITS-1:0] here, after;
        logic fin, st, emit_sym;
        logic [2:0] fk;
        logic [COUNT_BITS-1:0] fend;
        logic [3:0] fm;
        logic [2:0] kof;
        b = in_item.data_byte;
        here  = off_reg;
        after = (off_reg != CMAX) ? off_reg + ONE : off_reg;
        mode_next = mode_reg; off_next = off_reg; line_next = line_reg; col_next = col_reg;
        tstart_next = tstart_reg; tline_next = tline_reg; tcol_next = tcol_reg;
        esc_next = esc_reg; star_next = star_reg; dlen_next = dlen_reg; bcnt_next = bcnt_reg;
        grp_next = '0;
        fin = 1'b0; st = 1'b0; fk = ctc_pkg::KIND_SPACE; fend = here; emit_sym = 1'b0;
        fm = M_IDLE; kof = ctc_pkg::KIND_SPACE;
        if (in_item.has_byte)
        begin
            unique case (mode_reg)
                M_WS:
                    if (!ctc_pkg::is_space(b))
                    begin
                        fin = 1'b1; fk = ctc_pkg::KIND_SPACE; st = 1'b1;
                    end
                M_LINE:
                    if (b == ctc_pkg::CH_NL)
                    begin
                        fin = 1'b1; fk = ctc_pkg::KIND_COMMENT; st = 1'b1;
                    end
                M_BLOCK:
                    if (star_reg && b == ctc_pkg::CH_SLASH)
                    begin
                        fin = 1'b1; fk = ctc_pkg::KIND_COMMENT; fend = after;
                        mode_next = M_IDLE;
                    end
                    else
                        star_next = (b == ctc_pkg::CH_STAR);
                M_SLASH:
                    if (b == ctc_pkg::CH_SLASH)
                        mode_next = M_LINE;
                    else if (b == ctc_pkg::CH_STAR)
                    begin
                        mode_next = M_BLOCK; star_next = 1'b0;
                    end
                    else
                    begin
                        fin = 1'b1; fk = ctc_pkg::KIND_SYMBOL; st = 1'b1;
                    end
                M_RPEND:
                    if (b == ctc_pkg::CH_DQUOTE)
                    begin
                        mode_next = M_RAWDELIM; dlen_next = '0;
                    end
                    else if (ctc_pkg::is_word(b))
                        mode_next = M_IDENT;
                    else
                    begin
                        fin = 1'b1; fk = ctc_pkg::KIND_IDENT; st = 1'b1;
                    end
                M_IDENT:
                    if (!ctc_pkg::is_word(b))
                    begin
                        fin = 1'b1; fk = ctc_pkg::KIND_IDENT; st = 1'b1;
                    end
                M_NUMBER:
                    if (!(ctc_pkg::is_word(b) || b == ctc_pkg::CH_DOT))
                    begin
                        fin = 1'b1; fk = ctc_pkg::KIND_NUMBER; st = 1'b1;
                    end
                M_STRING, M_CHAR:
                    if (esc_reg)
                        esc_next = 1'b0;
                    else if (b == ctc_pkg::CH_BSLASH)
                        esc_next = 1'b1;
                    else if (b == ((mode_reg == M_STRING) ? ctc_pkg::CH_DQUOTE
                                                           : ctc_pkg::CH_SQUOTE))
                    begin
                        fin = 1'b1; fend = after; mode_next = M_IDLE;
                        fk = (mode_reg == M_STRING) ? ctc_pkg::KIND_STRING
                                                    : ctc_pkg::KIND_CHAR;
                    end
                M_RAWDELIM:
                    if (b == ctc_pkg::CH_LPAREN)
                    begin
                        mode_next = M_RAWBODY; bcnt_next = '0;
                    end
                    else if (32'(dlen_reg) >= MAX_DELIM)
                        mode_next = M_RAWOVF;
                    else
                        dlen_next = dlen_reg + DL_W'(1);
                M_RAWBODY:
                begin
                    if (32'(bcnt_reg) < HIST_LEN)
                        bcnt_next = bcnt_reg + BC_W'(1);
                    if (closed)
                    begin
                        fin = 1'b1; fk = ctc_pkg::KIND_STRING; fend = after;
                        mode_next = M_IDLE;
                    end
                end
                M_RAWOVF: ;
                default:
                    st = 1'b1;
            endcase
            if (fin)
                grp_next.v0 = 1'b1;
            grp_next.t0 = mk(fk, tstart_reg, fend, tline_reg, tcol_reg, 1'b0, 1'b0);
            if (st)
            begin
                tstart_next = off_reg; tline_next = line_reg; tcol_next = col_reg;
                if (ctc_pkg::is_space(b))
                    mode_next = M_WS;
                else if (b == ctc_pkg::CH_SLASH)
                    mode_next = M_SLASH;
                else if (b == ctc_pkg::CH_R)
                    mode_next = M_RPEND;
                else if (b == ctc_pkg::CH_DQUOTE)
                begin
                    mode_next = M_STRING; esc_next = 1'b0;
                end
                else if (b == ctc_pkg::CH_SQUOTE)
                begin
                    mode_next = M_CHAR; esc_next = 1'b0;
                end
                else if (ctc_pkg::is_alpha(b) || b == ctc_pkg::CH_UNDER)
                    mode_next = M_IDENT;
                else if (ctc_pkg::is_digit(b))
                    mode_next = M_NUMBER;
                else
                begin
                    emit_sym = 1'b1; mode_next = M_IDLE;
                end
            end
            grp_next.v1 = emit_sym;
            grp_next.t1 = mk(ctc_pkg::KIND_SYMBOL, off_reg, after, line_reg, col_reg,
                             1'b0, 1'b0);
            off_next = after;
            if (b == ctc_pkg::CH_NL)
            begin
                line_next = (line_reg != CMAX) ? line_reg + ONE : line_reg;
                col_next = ONE;
            end
            else
                col_next = (col_reg != CMAX) ? col_reg + ONE : col_reg;
        end
        if (in_item.end_of_input)
        begin
            fm = mode_next;
            unique case (fm)
                M_WS:                            kof = ctc_pkg::KIND_SPACE;
                M_LINE, M_BLOCK:                 kof = ctc_pkg::KIND_COMMENT;
                M_SLASH:                         kof = ctc_pkg::KIND_SYMBOL;
                M_RPEND, M_IDENT:                kof = ctc_pkg::KIND_IDENT;
                M_NUMBER:                        kof = ctc_pkg::KIND_NUMBER;
                M_CHAR:                          kof = ctc_pkg::KIND_CHAR;
                default:                         kof = ctc_pkg::KIND_STRING;
            endcase
            // a flushed token sits in a free slot: the closing slot if the byte did not
            // close one, else the open token was just started and symbol slot is free
            if (fm != M_IDLE)
            begin
                if (!grp_next.v0)
                begin
                    grp_next.v0 = 1'b1;
                    grp_next.t0 = mk(kof, tstart_next, off_next, tline_next, tcol_next,
                                     fm == M_RAWOVF, 1'b0);
                end
                else
                begin
                    grp_next.v1 = 1'b1;
                    grp_next.t1 = mk(kof, tstart_next, off_next, tline_next, tcol_next,
                                     fm == M_RAWOVF, 1'b0);
                end
            end
            grp_next.v2 = 1'b1;
            grp_next.t2 = mk(ctc_pkg::KIND_END, off_next, off_next, line_next, col_next,
                             1'b0, 1'b1);
            mode_next = M_IDLE; off_next = '0; line_next = ONE; col_next = ONE;
            tstart_next = '0; tline_next = ONE; tcol_next = ONE;
            esc_next = 1'b0; star_next = 1'b0; dlen_next = '0; bcnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE; off_reg <= '0; line_reg <= ONE; col_reg <= ONE;
            tstart_reg <= '0; tline_reg <= ONE; tcol_reg <= ONE;
            esc_reg <= 1'b0; star_reg <= 1'b0; dlen_reg <= '0; bcnt_reg <= '0;
            grp_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                mode_reg <= mode_next; off_reg <= off_next; line_reg <= line_next;
                col_reg <= col_next; tstart_reg <= tstart_next; tline_reg <= tline_next;
                tcol_reg <= tcol_next; esc_reg <= esc_next; star_reg <= star_next;
                dlen_reg <= dlen_next; bcnt_reg <= bcnt_next;
                grp_valid_reg <= grp_next.v0 || grp_next.v1 || grp_next.v2;
            end
            else if (grp_ready)
                grp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            grp_reg <= grp_next;
            if (in_item.has_byte && mode_reg == M_RAWDELIM && b != ctc_pkg::CH_LPAREN
                && 32'(dlen_reg) < MAX_DELIM)
                delim_reg[dlen_reg[$clog2(MAX_DELIM > 1 ? MAX_DELIM : 2)-1:0]] <= b;
            if (in_item.has_byte && mode_reg == M_RAWBODY)
                for (int i = 0; i < HIST_LEN; i++)
                    hist_reg[i] <= nh[i];
        end
    end
endmodule

// ===== sv/ctc_queue.sv =====
// short queue of token groups between front and back
// depends on ctc_pkg
module ctc_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_valid,
    input  ctc_pkg::token_group_t wr_data,
    output logic                  wr_ready,
    output logic                  rd_valid,
    output ctc_pkg::token_group_t rd_data,
    input  logic                  rd_ready
);
    localparam int D  = ctc_pkg::QUEUE_DEPTH;
    localparam int AW = $clog2(D);

    ctc_pkg::token_group_t mem_reg [D];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic wr, rd;

    assign wr_ready = (32'(cnt_reg) < D);
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + AW'(1);
            if (rd)
                rp_reg <= rp_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end
endmodule

// ===== sv/ctc_back.sv =====
// back end: serializes each token group into single token transfers
// depends on ctc_pkg
module ctc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  grp_valid,
    input  ctc_pkg::token_group_t grp,
    output logic                  grp_ready,
    output logic                  out_valid,
    output ctc_pkg::out_item_t    out_item,
    input  logic                  out_ready
);
    logic [2:0] done_reg, done_next;
    logic [2:0] pend;
    logic       sel_any;
    ctc_pkg::out_item_t sel;
    logic [2:0] sel_bit;

    assign pend = {grp.v2, grp.v1, grp.v0} & ~done_reg;

    always_comb
    begin
        sel = grp.t2; sel_bit = 3'b100;
        priority if (pend[0])
        begin
            sel = grp.t0; sel_bit = 3'b001;
        end
        else if (pend[1])
        begin
            sel = grp.t1; sel_bit = 3'b010;
        end
        else
        begin
            sel = grp.t2; sel_bit = 3'b100;
        end
    end

    assign sel_any   = grp_valid && (pend != '0);
    assign out_valid = sel_any;
    assign out_item  = sel;
    // group retires when its last pending token transfers
    assign grp_ready = grp_valid && ((pend == '0) || (out_ready && (pend == sel_bit)));

    always_comb
    begin
        done_next = done_reg;
        if (grp_ready)
            done_next = '0;
        else if (sel_any && out_ready)
            done_next = done_reg | sel_bit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= '0;
        else
            done_reg <= done_next;
    end
endmodule

// ===== sv/cpp_source_token_classifier.sv =====
// a token is offered once its group has passed the front group register and the queue,
// and a stall at the queue or at the output can hold it there
// throughput: one byte per cycle while each byte yields at most one token and out_ready
// stays high; the output side moves one token per cycle, so bytes yielding two or three
// tokens hold the input back; the queue between lexer and output hides short output stalls
// reset: asynchronous active low, lexer returns to idle with offset 0, line and column 1
module cpp_source_token_classifier #(
    parameter int MAX_DELIM  = ctc_pkg::MAX_DELIM_DEF,
    parameter int COUNT_BITS = ctc_pkg::COUNT_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ctc_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ctc_pkg::out_item_t out_data
);
    logic f_valid, f_ready, q_valid, q_ready;
    ctc_pkg::token_group_t f_grp, q_grp;

    ctc_front #(.MAX_DELIM(MAX_DELIM), .COUNT_BITS(COUNT_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_item(in_data),
        .in_ready(in_ready), .grp_valid(f_valid), .grp(f_grp), .grp_ready(f_ready)
    );

    ctc_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_data(f_grp),
        .wr_ready(f_ready), .rd_valid(q_valid), .rd_data(q_grp), .rd_ready(q_ready)
    );

    ctc_back u_back (
        .clk(clk), .rst_n(rst_n), .grp_valid(q_valid), .grp(q_grp), .grp_ready(q_ready),
        .out_valid(out_valid), .out_item(out_data), .out_ready(out_ready)
    );
endmodule

// ===== sv/ctc_checker.sv =====
// port-level checker for the token classifier, bound to the top level
// depends on ctc_pkg and cpp_source_token_classifier_macros.svh
`include "cpp_source_token_classifier_macros.svh"
module ctc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input ctc_pkg::out_item_t out_data
);
    logic otx;
    assign otx = out_valid && out_ready;

    `CTC_ASSERT_IMP(a_last_is_end, clk, rst_n, out_valid,
        out_data.last_token == (out_data.token_kind == ctc_pkg::KIND_END), "last flag")
    `CTC_ASSERT_IMP(a_end_zero_len, clk, rst_n,
        out_valid && out_data.last_token, out_data.token_length == '0, "end length")
    `CTC_ASSERT_IMP(a_ovf_string, clk, rst_n, out_valid && out_data.delim_overflow,
        out_data.token_kind == ctc_pkg::KIND_STRING, "overflow kind")
    `CTC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_data), "stalled token changed")
    `CTC_ASSERT_NXT(a_restart, clk, rst_n, otx && out_data.last_token,
        !out_valid || out_data.start_offset == '0 || out_data.last_token,
        "stream restart")
endmodule

bind cpp_source_token_classifier ctc_checker u_ctc_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
);

// ===== tb/token_checker.sv =====
// token classifier checker: watches both channels, predicts tokens, compares them
// depends on ctc_pkg for the item structs, kind codes and character constants
`timescale 1ns / 100ps
module token_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  ctc_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  ctc_pkg::out_item_t out_data,
    output int                 fail_count,
    output int                 pending_tokens
);
    import ctc_pkg::*;

    localparam int DELIM_MAX = 16;
    localparam int HIST_N    = DELIM_MAX + 2;
    localparam logic [23:0] CNT_TOP = 24'hffffff;

    typedef enum logic [3:0] {
        LX_IDLE, LX_WS, LX_LINE, LX_BLOCK, LX_SLASH, LX_RPEND, LX_IDENT, LX_NUMBER,
        LX_STRING, LX_CHAR, LX_RAWDELIM, LX_RAWBODY, LX_RAWOVF
    } lex_state_t;

    lex_state_t  lx;
    logic [23:0] pos, line_no, col_no, tok_pos, tok_line, tok_col;
    logic        esc, star;
    logic [7:0]  delim [DELIM_MAX];
    int          delim_len;
    logic [7:0]  hist [HIST_N];
    int          hist_cnt;
    out_item_t   token_q [$];

    assign pending_tokens = token_q.size();

    function automatic logic [23:0] bump(input logic [23:0] v);
        return (v == CNT_TOP) ? v : v + 24'd1;
    endfunction

    function automatic logic [2:0] kind_of_state(input lex_state_t s);
        case (s)
            LX_WS:                          return KIND_SPACE;
            LX_LINE, LX_BLOCK:              return KIND_COMMENT;
            LX_SLASH:                       return KIND_SYMBOL;
            LX_RPEND, LX_IDENT:             return KIND_IDENT;
            LX_NUMBER:                      return KIND_NUMBER;
            LX_CHAR:                        return KIND_CHAR;
            default:                        return KIND_STRING;
        endcase
    endfunction

    task automatic clear_lexer();
        lx = LX_IDLE;
        pos = 24'd0;
        line_no = 24'd1;
        col_no = 24'd1;
        tok_pos = 24'd0;
        tok_line = 24'd1;
        tok_col = 24'd1;
        esc = 1'b0;
        star = 1'b0;
        delim_len = 0;
        hist_cnt = 0;
    endtask

    task automatic push_token(input logic [2:0] k, input logic [23:0] off,
                              input logic [23:0] len, input logic [23:0] ln,
                              input logic [23:0] col, input logic ovf, input logic last);
        out_item_t t;
        t.token_kind = k;
        t.start_offset = off;
        t.token_length = len;
        t.first_line = ln;
        t.first_column = col;
        t.delim_overflow = ovf;
        t.last_token = last;
        token_q = {token_q, t};
    endtask

    task automatic close_token(input logic [2:0] k, input logic [23:0] stop, input logic ovf);
        push_token(k, tok_pos, (stop >= tok_pos) ? stop - tok_pos : 24'd0,
                   tok_line, tok_col, ovf, 1'b0);
        lx = LX_IDLE;
    endtask

    task automatic open_token(input logic [7:0] b);
        tok_pos = pos;
        tok_line = line_no;
        tok_col = col_no;
        if (is_space(b)) lx = LX_WS;
        else if (b == CH_SLASH) lx = LX_SLASH;
        else if (b == CH_R) lx = LX_RPEND;
        else if (b == CH_DQUOTE || b == CH_SQUOTE)
        begin
            lx = (b == CH_DQUOTE) ? LX_STRING : LX_CHAR;
            esc = 1'b0;
        end
        else if (is_alpha(b) || b == CH_UNDER) lx = LX_IDENT;
        else if (is_digit(b)) lx = LX_NUMBER;
        else close_token(KIND_SYMBOL, bump(pos), 1'b0);
    endtask

    function automatic logic raw_done();
        if (hist_cnt < delim_len + 2) return 1'b0;
        if (hist[0] != CH_DQUOTE || hist[delim_len + 1] != CH_RPAREN) return 1'b0;
        for (int k = 1; k <= delim_len; k++)
            if (hist[k] != delim[delim_len - k]) return 1'b0;
        return 1'b1;
    endfunction

    // returns 1 when the byte also opens a new token
    task automatic lex_byte(input logic [7:0] b, output logic reopen);
        logic [23:0] nxt;
        nxt = bump(pos);
        reopen = 1'b0;
        case (lx)
            LX_WS:
                if (!is_space(b))
                begin
                    close_token(KIND_SPACE, pos, 1'b0);
                    reopen = 1'b1;
                end
            LX_LINE:
                if (b == CH_NL)
                begin
                    close_token(KIND_COMMENT, pos, 1'b0);
                    reopen = 1'b1;
                end
            LX_BLOCK:
                if (star && b == CH_SLASH) close_token(KIND_COMMENT, nxt, 1'b0);
                else star = (b == CH_STAR);
            LX_SLASH:
                if (b == CH_SLASH) lx = LX_LINE;
                else if (b == CH_STAR)
                begin
                    lx = LX_BLOCK;
                    star = 1'b0;
                end
                else
                begin
                    close_token(KIND_SYMBOL, pos, 1'b0);
                    reopen = 1'b1;
                end
            LX_RPEND:
                if (b == CH_DQUOTE)
                begin
                    lx = LX_RAWDELIM;
                    delim_len = 0;
                end
                else
                begin
                    lx = LX_IDENT;
                    if (!is_word(b))
                    begin
                        close_token(KIND_IDENT, pos, 1'b0);
                        reopen = 1'b1;
                    end
                end
            LX_IDENT:
                if (!is_word(b))
                begin
                    close_token(KIND_IDENT, pos, 1'b0);
                    reopen = 1'b1;
                end
            LX_NUMBER:
                if (!(is_word(b) || b == CH_DOT))
                begin
                    close_token(KIND_NUMBER, pos, 1'b0);
                    reopen = 1'b1;
                end
            LX_STRING, LX_CHAR:
                if (esc) esc = 1'b0;
                else if (b == CH_BSLASH) esc = 1'b1;
                else if (b == ((lx == LX_STRING) ? CH_DQUOTE : CH_SQUOTE))
                    close_token((lx == LX_STRING) ? KIND_STRING : KIND_CHAR, nxt, 1'b0);
            LX_RAWDELIM:
                if (b == CH_LPAREN)
                begin
                    lx = LX_RAWBODY;
                    hist_cnt = 0;
                end
                else if (delim_len >= DELIM_MAX) lx = LX_RAWOVF;
                else
                begin
                    delim[delim_len] = b;
                    delim_len++;
                end
            LX_RAWBODY:
            begin
                for (int k = HIST_N - 1; k > 0; k--) hist[k] = hist[k - 1];
                hist[0] = b;
                if (hist_cnt < HIST_N) hist_cnt++;
                if (raw_done()) close_token(KIND_STRING, nxt, 1'b0);
            end
            LX_RAWOVF: ;
            default: reopen = 1'b1;
        endcase
    endtask

    task automatic predict(input in_item_t it);
        logic reopen;
        if (it.has_byte)
        begin
            lex_byte(it.data_byte, reopen);
            if (reopen) open_token(it.data_byte);
            pos = bump(pos);
            if (it.data_byte == CH_NL)
            begin
                line_no = bump(line_no);
                col_no = 24'd1;
            end
            else
                col_no = bump(col_no);
        end
        if (it.end_of_input)
        begin
            if (lx != LX_IDLE) close_token(kind_of_state(lx), pos, lx == LX_RAWOVF);
            push_token(KIND_END, pos, 24'd0, line_no, col_no, 1'b0, 1'b1);
            clear_lexer();
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            fail_count = 0;
            clear_lexer();
            token_q.delete();
        end
        else
        begin
            if (in_valid && in_ready) predict(in_data);
            if (out_valid && out_ready)
            begin
                if (token_q.size() == 0)
                begin
                    $display("%0t: unexpected token kind=%0d off=%0d len=%0d", $time,
                             out_data.token_kind, out_data.start_offset,
                             out_data.token_length);
                    fail_count++;
                end
                else
                begin
                    want = token_q.pop_front();
                    if (out_data.token_kind !== want.token_kind ||
                        out_data.start_offset !== want.start_offset ||
                        out_data.token_length !== want.token_length ||
                        out_data.first_line !== want.first_line ||
                        out_data.first_column !== want.first_column ||
                        out_data.delim_overflow !== want.delim_overflow ||
                        out_data.last_token !== want.last_token)
                    begin
                        $display("%0t: expected k=%0d o=%0d n=%0d l=%0d c=%0d v=%0b e=%0b",
                                 $time, want.token_kind, want.start_offset,
                                 want.token_length, want.first_line, want.first_column,
                                 want.delim_overflow, want.last_token);
                        $display("%0t: actual   k=%0d o=%0d n=%0d l=%0d c=%0d v=%0b e=%0b",
                                 $time, out_data.token_kind, out_data.start_offset,
                                 out_data.token_length, out_data.first_line,
                                 out_data.first_column, out_data.delim_overflow,
                                 out_data.last_token);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/tb_top.sv =====
// top of the token classifier testbench: clock, reset, source stimulus, verdict
// depends on ctc_pkg, cpp_source_token_classifier and token_checker
`timescale 1ns / 100ps
module tb_top;
    import ctc_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    int        fail_count;
    int        pending_tokens;
    int        items_sent;
    int        tokens_taken;
    int        ready_gap;
    logic      calm;
    byte       src_q [$];

    cpp_source_token_classifier u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    token_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .fail_count     (fail_count),
        .pending_tokens (pending_tokens)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    initial
    begin
        #2ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver: random gaps, one long hold-off so the block backs up into its input
    initial
    begin
        out_ready = 1'b0;
        tokens_taken = 0;
        ready_gap = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                tokens_taken++;
                ready_gap = calm ? 0 : $urandom_range(0, 3);
                if (tokens_taken == 40) ready_gap = 150;
            end
            if (ready_gap > 0)
            begin
                out_ready <= 1'b0;
                ready_gap--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send_item(input logic [7:0] b, input logic has, input logic eoi);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{data_byte: b, has_byte: has, end_of_input: eoi};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (has || eoi) items_sent++;
    endtask

    task automatic add_byte(input int v);
        src_q = {src_q, byte'(v)};
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    function automatic byte any_letter();
        int base;
        base = ($urandom_range(0, 1) != 0) ? 'h61 : 'h41;
        return byte'(base + int'($urandom_range(0, 25)));
    endfunction

    // one source fragment with random content, mostly well-formed
    task automatic add_fragment();
        int n;
        int dl;
        int ch;
        byte d [$];
        n = $urandom_range(1, 6);
        case ($urandom_range(0, 11))
            0, 1:
            begin
                if ($urandom_range(0, 3) == 0) add_byte(CH_R);
                repeat (n)
                    add_byte(($urandom_range(0, 4) == 0) ? int'(CH_UNDER)
                                                         : int'(any_letter()));
            end
            2:
            begin
                add_byte('h30 + int'($urandom_range(0, 9)));
                repeat (n)
                    add_byte(($urandom_range(0, 3) == 0) ? int'(CH_DOT)
                             : 'h30 + int'($urandom_range(0, 9)));
            end
            3, 4:
                repeat (n)
                    case ($urandom_range(0, 3))
                        0: add_byte(CH_NL);
                        1: add_byte(9 + int'($urandom_range(0, 4)));
                        default: add_byte(CH_SPACE);
                    endcase
            5, 6:
            begin
                dl = ($urandom_range(0, 1) != 0) ? int'(CH_DQUOTE) : int'(CH_SQUOTE);
                add_byte(dl);
                repeat (n)
                    case ($urandom_range(0, 4))
                        0:
                        begin
                            add_byte(CH_BSLASH);
                            add_byte(int'($urandom));
                        end
                        1: add_byte(int'(CH_DQUOTE) + int'(CH_SQUOTE) - dl);
                        default: add_byte('h20 + int'($urandom_range(0, 94)));
                    endcase
                if ($urandom_range(0, 15) != 0) add_byte(dl);
            end
            7:
            begin
                add_text("//");
                repeat (n) add_byte('h20 + int'($urandom_range(0, 94)));
                add_byte(CH_NL);
            end
            8:
            begin
                add_text("/*");
                repeat (n) add_byte(($urandom_range(0, 2) == 0) ? int'(CH_STAR)
                                    : (($urandom_range(0, 3) == 0) ? int'(CH_SLASH)
                                    : int'(any_letter())));
                if ($urandom_range(0, 15) != 0) add_text("*/");
            end
            9, 10:
            begin
                dl = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20)
                                                 : $urandom_range(0, 16);
                repeat (dl)
                begin
                    ch = 'h21 + int'($urandom_range(0, 93));
                    if (ch == int'(CH_LPAREN)) ch = int'(CH_UNDER);
                    d = {d, byte'(ch)};
                end
                add_text("R\"");
                foreach (d[i]) add_byte(d[i]);
                if ($urandom_range(0, 15) != 0)
                begin
                    add_byte(CH_LPAREN);
                    repeat (n)
                        case ($urandom_range(0, 3))
                            0: add_byte(CH_RPAREN);
                            1: add_byte(CH_DQUOTE);
                            default: add_byte(int'($urandom));
                        endcase
                    if ($urandom_range(0, 7) != 0)
                    begin
                        add_byte(CH_RPAREN);
                        foreach (d[i]) add_byte(d[i]);
                        add_byte(CH_DQUOTE);
                    end
                end
            end
            default:
                repeat (n) add_byte(int'($urandom));
        endcase
    endtask

    // push one source out, idle items mixed in, then close it
    task automatic send_source(input logic last_has);
        logic [7:0] b;
        while (src_q.size() > 0)
        begin
            if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            b = src_q.pop_front();
            if (src_q.size() == 0 && last_has) send_item(b, 1'b1, 1'b1);
            else send_item(b, 1'b1, 1'b0);
        end
        if (!last_has) send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        calm = 1'b0;
        items_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every token kind, escapes, raw string with delimiter, lone slash, R starting a plain identifier
        add_text("R\"ab(x)\"ab)ab\"/*a*/x//c\n'\\''\"\\\"\" _9 3.e/ Rq\t");
        add_byte('hff);
        add_byte('h00);
        send_source(1'b0);
        send_item(8'h80, 1'b0, 1'b1);
        add_byte('h80);
        send_source(1'b1);

        while (items_sent < 420)
        begin
            calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 8)) add_fragment();
            send_source(1'($urandom_range(0, 1)));
        end
        in_valid <= 1'b0;
        while (pending_tokens != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
